/* hdl/pbe_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pbe_pkg
// Types, codes and helpers shared by the pixel blit engine modules.
// ----------------------------------------------------------------------------
package pbe_pkg;

    localparam int ADDR_W      = 16;
    localparam int STORE_WORDS = 1 << ADDR_W;
    localparam int WORDS_W     = ADDR_W + 1;
    localparam int DIM_W       = 13;
    localparam int MAX_DIM     = 4096;
    localparam int OFF_W       = 2 * DIM_W;
    localparam int DIV_CNT_W   = 4;
    localparam int PIX_W       = 32;

    localparam logic [2:0] REQ_WRITE = 3'd0;
    localparam logic [2:0] REQ_READ  = 3'd1;
    localparam logic [2:0] REQ_FILL  = 3'd2;
    localparam logic [2:0] REQ_COPY  = 3'd3;
    localparam logic [2:0] REQ_BUF   = 3'd4;
    localparam logic [2:0] REQ_SCALE = 3'd5;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_SKIP  = 2'd1;
    localparam logic [1:0] STAT_BOUND = 2'd2;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [ADDR_W-1:0]  src_start;
        logic [WORDS_W-1:0] src_words;
        logic [DIM_W-1:0]   src_width;
        logic [DIM_W-1:0]   src_height;
        logic [DIM_W-1:0]   src_row_pitch;
        logic [ADDR_W-1:0]  dst_start;
        logic [WORDS_W-1:0] dst_words;
        logic [DIM_W-1:0]   dst_width;
        logic [DIM_W-1:0]   dst_height;
        logic [PIX_W-1:0]   pixel_value;
    } pbe_req_t;

    typedef struct packed {
        logic [PIX_W-1:0]   read_data;
        logic [WORDS_W-1:0] pixels_written;
        logic [1:0]         status;
    } pbe_rsp_t;

    typedef struct packed {
        logic             start;
        logic [DIM_W-1:0] num;
        logic [DIM_W-1:0] den;
    } div_cmd_t;

    typedef struct packed {
        logic             done;
        logic [DIM_W-1:0] quo;
        logic [DIM_W-1:0] rem;
    } div_rsp_t;

    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
        return (v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
    endfunction

endpackage
`default_nettype wire

/* hdl/pixel_blit_engine_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_blit_engine_unit
// Pixel store with write, read, fill, copy and nearest-neighbour scale.
// ----------------------------------------------------------------------------
// A pixel write or read goes from acceptance straight to the result state.
// A fill writes its N words in turn through the single store write port.
// Copies read each pixel and then write it back, with a row check before
// each row and setup first; a scaled copy adds two 13-step divisions.
// Reset clears the control state only; the store is undefined until written
// and gets no clearing pass, so items are accepted right after reset.
// ----------------------------------------------------------------------------
module pixel_blit_engine_unit import pbe_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire pbe_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output pbe_rsp_t      rsp
);

    typedef enum logic [10:0] {
        ST_IDLE = 11'b00000000001,
        ST_PREP = 11'b00000000010,
        ST_FCHK = 11'b00000000100,
        ST_FILL = 11'b00000001000,
        ST_DIVX = 11'b00000010000,
        ST_DIVY = 11'b00000100000,
        ST_MULS = 11'b00001000000,
        ST_ROW  = 11'b00010000000,
        ST_RD   = 11'b00100000000,
        ST_WR   = 11'b01000000000,
        ST_FIN  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]         req_reg;
    logic [ADDR_W-1:0]  sbase_reg, dbase_reg, rd_addr_reg;
    logic [WORDS_W-1:0] swords_reg, dwords_reg;
    logic [DIM_W-1:0]   sw_reg, sh_reg, pitch_reg, dw_reg, dh_reg;
    logic [PIX_W-1:0]   pix_reg;
    logic [WORDS_W-1:0] count_reg, limit_reg;
    logic [1:0]         status_reg;
    logic [OFF_W-1:0]   prod_reg, sstep_reg, so_reg, dof_reg;
    logic [DIM_W-1:0]   w_reg, h_reg, len_reg, y_reg, x_reg, scol_reg;
    logic [DIM_W-1:0]   qx_reg, qy_reg, rx_inc_reg, ry_inc_reg, rx_reg, ry_reg;
    logic               rsp_valid_reg;
    pbe_rsp_t           rsp_reg;

    logic               acc;
    logic               rsp_load;
    logic               div_done;
    div_cmd_t           div_cmd;
    div_rsp_t           div_rsp;

    logic [DIM_W-1:0]   min_w, min_h, bw, bh, rp;
    logic [DIM_W-1:0]   p_w, p_h, p_len;
    logic [OFF_W-1:0]   p_sstep;
    logic               p_skip;

    logic               row_bound, last_col;
    logic [DIM_W:0]     sum_rx, sum_ry;
    logic [OFF_W-1:0]   src_sum, dst_sum, fill_sum;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
    logic [PIX_W-1:0]   mem_wdata, rd_q;
    logic [PIX_W-1:0]   store_mem [STORE_WORDS];

    assign req_ready = (state_reg == ST_IDLE);
    assign acc       = req_valid && req_ready;
    assign rsp_load  = (state_reg == ST_FIN) && (!rsp_valid_reg || rsp_ready);
    assign div_done  = div_rsp.done;

    // Request setup, from the captured and saturated fields.
    always_comb
    begin
        min_w   = (sw_reg < dw_reg) ? sw_reg : dw_reg;
        min_h   = (sh_reg < dh_reg) ? sh_reg : dh_reg;
        bw      = ((sw_reg == '0) || (sw_reg > dw_reg)) ? dw_reg : sw_reg;
        bh      = ((sh_reg == '0) || (sh_reg > dh_reg)) ? dh_reg : sh_reg;
        rp      = (pitch_reg < bw) ? bw : pitch_reg;
        p_w     = dw_reg;
        p_h     = dh_reg;
        p_len   = sw_reg;
        p_sstep = '0;
        p_skip  = 1'b1;
        case (req_reg)
            REQ_FILL:
            begin
                p_skip = (dw_reg == '0) || (dh_reg == '0) || (dwords_reg == '0);
            end
            REQ_COPY:
            begin
                p_w     = min_w;
                p_h     = min_h;
                p_len   = min_w;
                p_sstep = OFF_W'(sw_reg);
                p_skip  = (swords_reg == '0) || (dwords_reg == '0) ||
                          (min_w == '0) || (min_h == '0);
            end
            REQ_BUF:
            begin
                p_w     = bw;
                p_h     = bh;
                p_len   = bw;
                p_sstep = OFF_W'(rp);
                p_skip  = (swords_reg == '0) || (dwords_reg == '0) ||
                          (bw == '0) || (bh == '0);
            end
            REQ_SCALE:
            begin
                p_skip = (sbase_reg == dbase_reg) || (swords_reg == '0) ||
                         (dwords_reg == '0) || (sw_reg == '0) || (sh_reg == '0) ||
                         (dw_reg == '0) || (dh_reg == '0);
            end
            default:
            begin
                p_skip = 1'b1;
            end
        endcase
    end

    assign row_bound = ((so_reg + OFF_W'(len_reg)) > OFF_W'(swords_reg)) ||
                       ((dof_reg + OFF_W'(w_reg)) > OFF_W'(dwords_reg));
    assign last_col  = (x_reg + 1'b1) == w_reg;
    assign sum_rx    = {1'b0, rx_reg} + {1'b0, rx_inc_reg};
    assign sum_ry    = {1'b0, ry_reg} + {1'b0, ry_inc_reg};
    assign src_sum   = OFF_W'(sbase_reg) + so_reg + OFF_W'(scol_reg);
    assign dst_sum   = OFF_W'(dbase_reg) + dof_reg + OFF_W'(x_reg);
    assign fill_sum  = OFF_W'(dbase_reg) + OFF_W'(count_reg);

    always_comb
    begin
        div_cmd.start = ((state_reg == ST_PREP) && (req_reg == REQ_SCALE) && !p_skip) ||
                        ((state_reg == ST_DIVX) && div_done);
        div_cmd.num   = (state_reg == ST_PREP) ? sw_reg : sh_reg;
        div_cmd.den   = (state_reg == ST_PREP) ? dw_reg : dh_reg;
    end

    pbe_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    if ((req.req_type == REQ_WRITE) || (req.req_type == REQ_READ))
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                if (p_skip)
                begin
                    state_next = ST_FIN;
                end
                else if (req_reg == REQ_FILL)
                begin
                    state_next = ST_FCHK;
                end
                else if (req_reg == REQ_SCALE)
                begin
                    state_next = ST_DIVX;
                end
                else
                begin
                    state_next = ST_ROW;
                end
            end
            ST_FCHK: state_next = ST_FILL;
            ST_FILL:
            begin
                if ((count_reg + 1'b1) == limit_reg)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_DIVX:
            begin
                if (div_done)
                begin
                    state_next = ST_DIVY;
                end
            end
            ST_DIVY:
            begin
                if (div_done)
                begin
                    state_next = ST_MULS;
                end
            end
            ST_MULS: state_next = ST_ROW;
            ST_ROW:
            begin
                if ((y_reg == h_reg) || row_bound)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD: state_next = ST_WR;
            ST_WR: state_next = last_col ? ST_ROW : ST_RD;
            ST_FIN:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    req_reg     <= req.req_type;
                    sbase_reg   <= req.src_start;
                    dbase_reg   <= req.dst_start;
                    rd_addr_reg <= req.dst_start;
                    swords_reg  <= req.src_words;
                    dwords_reg  <= req.dst_words;
                    sw_reg      <= sat_dim(req.src_width);
                    sh_reg      <= sat_dim(req.src_height);
                    pitch_reg   <= sat_dim(req.src_row_pitch);
                    dw_reg      <= sat_dim(req.dst_width);
                    dh_reg      <= sat_dim(req.dst_height);
                    pix_reg     <= req.pixel_value;
                    count_reg   <= (req.req_type == REQ_WRITE) ? WORDS_W'(1) : '0;
                    status_reg  <= STAT_DONE;
                end
            end
            ST_PREP:
            begin
                prod_reg   <= OFF_W'(dw_reg) * OFF_W'(dh_reg);
                w_reg      <= p_w;
                h_reg      <= p_h;
                len_reg    <= p_len;
                sstep_reg  <= p_sstep;
                qx_reg     <= DIM_W'(1);
                rx_inc_reg <= '0;
                ry_inc_reg <= '0;
                ry_reg     <= '0;
                y_reg      <= '0;
                so_reg     <= '0;
                dof_reg    <= '0;
                status_reg <= p_skip ? STAT_SKIP : STAT_DONE;
            end
            ST_FCHK:
            begin
                if (prod_reg > OFF_W'(dwords_reg))
                begin
                    limit_reg  <= dwords_reg;
                    status_reg <= STAT_BOUND;
                end
                else
                begin
                    limit_reg <= prod_reg[WORDS_W-1:0];
                end
            end
            ST_FILL:
            begin
                count_reg <= count_reg + 1'b1;
            end
            ST_DIVX:
            begin
                if (div_done)
                begin
                    qx_reg     <= div_rsp.quo;
                    rx_inc_reg <= div_rsp.rem;
                end
            end
            ST_DIVY:
            begin
                if (div_done)
                begin
                    qy_reg     <= div_rsp.quo;
                    ry_inc_reg <= div_rsp.rem;
                end
            end
            ST_MULS:
            begin
                sstep_reg <= OFF_W'(qy_reg) * OFF_W'(sw_reg);
            end
            ST_ROW:
            begin
                x_reg    <= '0;
                scol_reg <= '0;
                rx_reg   <= '0;
                if ((y_reg != h_reg) && row_bound)
                begin
                    status_reg <= STAT_BOUND;
                end
            end
            ST_WR:
            begin
                count_reg <= count_reg + 1'b1;
                x_reg     <= x_reg + 1'b1;
                if (sum_rx >= {1'b0, dw_reg})
                begin
                    scol_reg <= scol_reg + qx_reg + 1'b1;
                    rx_reg   <= DIM_W'(sum_rx - {1'b0, dw_reg});
                end
                else
                begin
                    scol_reg <= scol_reg + qx_reg;
                    rx_reg   <= sum_rx[DIM_W-1:0];
                end
                if (last_col)
                begin
                    y_reg   <= y_reg + 1'b1;
                    dof_reg <= dof_reg + OFF_W'(dw_reg);
                    if (sum_ry >= {1'b0, dh_reg})
                    begin
                        so_reg <= so_reg + sstep_reg + OFF_W'(sw_reg);
                        ry_reg <= DIM_W'(sum_ry - {1'b0, dh_reg});
                    end
                    else
                    begin
                        so_reg <= so_reg + sstep_reg;
                        ry_reg <= sum_ry[DIM_W-1:0];
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (rsp_load)
        begin
            rsp_reg.read_data      <= (req_reg == REQ_READ) ? rd_q : '0;
            rsp_reg.pixels_written <= count_reg;
            rsp_reg.status         <= status_reg;
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = dst_sum[ADDR_W-1:0];
        mem_wdata = rd_q;
        mem_raddr = rd_addr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                mem_raddr = req.dst_start;
                if (acc && (req.req_type == REQ_WRITE))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = req.dst_start;
                    mem_wdata = req.pixel_value;
                end
            end
            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = fill_sum[ADDR_W-1:0];
                mem_wdata = pix_reg;
            end
            ST_RD:
            begin
                mem_raddr = src_sum[ADDR_W-1:0];
            end
            ST_WR:
            begin
                mem_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        rd_q <= store_mem[mem_raddr];
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WR) |-> ($past(state_reg) == ST_RD))
        else $error("Write-back without a preceding source read.");

    a_fill_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> (count_reg < limit_reg))
        else $error("Fill count passed its limit.");

    a_rx_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RD) || (state_reg == ST_WR)) |-> (rx_reg < dw_reg))
        else $error("Column remainder out of range.");

    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FIN) && rsp_valid_reg && !rsp_ready) |=> (state_reg == ST_FIN))
        else $error("Result dropped while the output item was stalled.");

endmodule
`default_nettype wire

/* hdl/pbe_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pbe_div
// Restoring divider, one quotient bit per cycle, for the scale step ratios.
// ----------------------------------------------------------------------------
module pbe_div import pbe_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_cmd_t cmd,
    output div_rsp_t      rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIM_W-1:0]     quo_reg;
    logic [DIM_W-1:0]     rem_reg;
    logic [DIM_W-1:0]     den_reg;
    logic [DIM_W:0]       trial;
    logic [DIM_W:0]       diff;
    logic                 ge;

    assign trial = {rem_reg, quo_reg[DIM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (cmd.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIM_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            quo_reg <= cmd.num;
            rem_reg <= '0;
            den_reg <= cmd.den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
            quo_reg <= {quo_reg[DIM_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule
`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives pixel_blit_engine_unit with a directed table and then random
// requests, with random idle cycles on both handshakes. Every response is
// compared with its table row or an in-bench model of the pixel store. The
// first request fills the whole store, so no read touches an unwritten word.
// ----------------------------------------------------------------------------
module testbench import pbe_pkg::*; ();

    localparam int WATCHDOG_LIMIT = 400000;
    localparam int RANDOM_ITEMS   = 1950;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    pbe_req_t req = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    pbe_rsp_t rsp;

    logic [PIX_W-1:0] pixel_mem [STORE_WORDS];
    pbe_rsp_t         pending_rsp [$];
    pbe_req_t         table_req [$];
    bit               table_typed [$];
    pbe_rsp_t         table_rsp [$];
    int               mismatches = 0;
    int               rsp_count = 0;
    int               idle_max = 6;
    int               stall_cycles = 0;

    pixel_blit_engine_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #4 clk = ~clk;

    function automatic longint clamp_dim(input logic [DIM_W-1:0] v);
        return (v > MAX_DIM) ? MAX_DIM : longint'(v);
    endfunction

    function automatic logic [ADDR_W-1:0] wrap_addr(input longint base, input longint off);
        return ADDR_W'(base + off);
    endfunction

    function automatic logic [1:0] move_rows(input longint sb, input longint swd,
                                            input longint sst, input longint db,
                                            input longint dwd, input longint dst,
                                            input longint w, input longint h,
                                            inout longint cnt);
        longint so;
        longint dof;
        for (longint y = 0; y < h; y++)
        begin
            so = y * sst;
            dof = y * dst;
            if (so + w > swd || dof + w > dwd)
                return STAT_BOUND;
            for (longint x = 0; x < w; x++)
            begin
                pixel_mem[wrap_addr(db, dof + x)] = pixel_mem[wrap_addr(sb, so + x)];
                cnt++;
            end
        end
        return STAT_DONE;
    endfunction

    function automatic pbe_rsp_t blit_predict(input pbe_req_t r);
        pbe_rsp_t res;
        longint   sb, swd, sw, sh, pitch, db, dwd, dw, dh;
        longint   cnt, n, w, h, rp, sy, so, dof;
        sb = longint'(r.src_start);
        swd = longint'(r.src_words);
        sw = clamp_dim(r.src_width);
        sh = clamp_dim(r.src_height);
        pitch = clamp_dim(r.src_row_pitch);
        db = longint'(r.dst_start);
        dwd = longint'(r.dst_words);
        dw = clamp_dim(r.dst_width);
        dh = clamp_dim(r.dst_height);
        cnt = 0;
        res = '0;
        res.status = STAT_DONE;
        case (r.req_type)
            REQ_WRITE:
            begin
                pixel_mem[r.dst_start] = r.pixel_value;
                cnt = 1;
            end
            REQ_READ:
                res.read_data = pixel_mem[r.dst_start];
            REQ_FILL:
            begin
                if (dw == 0 || dh == 0 || dwd == 0)
                    res.status = STAT_SKIP;
                else
                begin
                    n = dw * dh;
                    if (n > dwd)
                    begin
                        n = dwd;
                        res.status = STAT_BOUND;
                    end
                    for (longint k = 0; k < n; k++)
                        pixel_mem[wrap_addr(db, k)] = r.pixel_value;
                    cnt = n;
                end
            end
            REQ_COPY:
            begin
                w = (sw < dw) ? sw : dw;
                h = (sh < dh) ? sh : dh;
                if (swd == 0 || dwd == 0 || w == 0 || h == 0)
                    res.status = STAT_SKIP;
                else
                    res.status = move_rows(sb, swd, sw, db, dwd, dw, w, h, cnt);
            end
            REQ_BUF:
            begin
                w = (sw == 0 || sw > dw) ? dw : sw;
                h = (sh == 0 || sh > dh) ? dh : sh;
                if (w == 0 || h == 0 || swd == 0 || dwd == 0)
                    res.status = STAT_SKIP;
                else
                begin
                    rp = (pitch < w) ? w : pitch;
                    res.status = move_rows(sb, swd, rp, db, dwd, dw, w, h, cnt);
                end
            end
            REQ_SCALE:
            begin
                if (sb == db || swd == 0 || dwd == 0 || sw == 0 || sh == 0 ||
                    dw == 0 || dh == 0)
                    res.status = STAT_SKIP;
                else
                begin
                    for (longint y = 0; y < dh; y++)
                    begin
                        sy = (y * sh) / dh;
                        so = sy * sw;
                        dof = y * dw;
                        if (so + sw > swd || dof + dw > dwd)
                        begin
                            res.status = STAT_BOUND;
                            break;
                        end
                        for (longint x = 0; x < dw; x++)
                        begin
                            pixel_mem[wrap_addr(db, dof + x)] =
                                pixel_mem[wrap_addr(sb, so + (x * sw) / dw)];
                            cnt++;
                        end
                    end
                end
            end
            default:
                res.status = STAT_SKIP;
        endcase
        res.pixels_written = WORDS_W'(cnt);
        return res;
    endfunction

    function automatic logic [DIM_W-1:0] rand_dim(input bit wide);
        return wide ? DIM_W'($urandom) : DIM_W'($urandom_range(0, 12));
    endfunction

    function automatic pbe_req_t rand_request();
        pbe_req_t r;
        bit       wide;
        int       pick;
        pick = $urandom_range(0, 99);
        wide = ($urandom_range(0, 9) == 0);
        if (pick < 20)
            r.req_type = REQ_WRITE;
        else if (pick < 40)
            r.req_type = REQ_READ;
        else if (pick < 52)
            r.req_type = REQ_FILL;
        else if (pick < 66)
            r.req_type = REQ_COPY;
        else if (pick < 80)
            r.req_type = REQ_BUF;
        else if (pick < 96)
            r.req_type = REQ_SCALE;
        else
            r.req_type = 3'($urandom_range(6, 7));
        r.src_start = ADDR_W'($urandom);
        r.dst_start = ($urandom_range(0, 15) == 0) ? r.src_start : ADDR_W'($urandom);
        r.src_width = rand_dim(wide);
        r.src_height = rand_dim(wide);
        r.src_row_pitch = ($urandom_range(0, 3) == 0) ? DIM_W'($urandom) : rand_dim(wide);
        r.dst_width = rand_dim(wide);
        r.dst_height = rand_dim(wide);
        if (wide)
        begin
            r.src_words = WORDS_W'($urandom_range(0, 3000));
            r.dst_words = WORDS_W'($urandom_range(0, 3000));
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            r.src_words = WORDS_W'($urandom_range(0, STORE_WORDS));
            r.dst_words = WORDS_W'($urandom_range(0, STORE_WORDS));
        end
        else
        begin
            r.src_words = WORDS_W'($urandom_range(0, 200));
            r.dst_words = WORDS_W'($urandom_range(0, 200));
        end
        r.pixel_value = $urandom;
        return r;
    endfunction

    task automatic add_row(input pbe_req_t r, input bit typed, input pbe_rsp_t e);
        table_req.push_back(r);
        table_typed.push_back(typed);
        table_rsp.push_back(e);
    endtask

    task automatic offer_request(input pbe_req_t r, input bit typed, input pbe_rsp_t e);
        int       gap;
        pbe_rsp_t model_rsp;
        gap = $urandom_range(0, idle_max);
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        model_rsp = blit_predict(r);
        pending_rsp.push_back(typed ? e : model_rsp);
    endtask

    initial
    begin
        pbe_rsp_t none;
        none = '0;

        add_row('{REQ_FILL, 16'd0, 17'd0, 13'd0, 13'd0, 13'd0, 16'd0, 17'd65536,
                  13'd4096, 13'd16, 32'h1234_5678},
                1'b1, '{32'd0, 17'd65536, STAT_DONE});
        add_row('{REQ_WRITE, 16'hFFFF, 17'h1FFFF, 13'h1FFF, 13'h1FFF, 13'h1FFF,
                  16'hFFFF, 17'h1FFFF, 13'h1FFF, 13'h1FFF, 32'hFFFF_FFFF},
                1'b1, '{32'd0, 17'd1, STAT_DONE});
        add_row('{REQ_READ, 16'd0, 17'd0, 13'd0, 13'd0, 13'd0, 16'hFFFF, 17'd0,
                  13'd0, 13'd0, 32'd0},
                1'b1, '{32'hFFFF_FFFF, 17'd0, STAT_DONE});
        add_row('{REQ_WRITE, 16'd0, 17'd0, 13'd0, 13'd0, 13'd0, 16'd0, 17'd0,
                  13'd0, 13'd0, 32'd0},
                1'b1, '{32'd0, 17'd1, STAT_DONE});
        add_row('{REQ_READ, 16'd0, 17'd0, 13'd0, 13'd0, 13'd0, 16'd0, 17'd0,
                  13'd0, 13'd0, 32'd0},
                1'b1, '{32'd0, 17'd0, STAT_DONE});
        add_row('{3'd6, 16'd5, 17'd9, 13'd3, 13'd3, 13'd0, 16'd20, 17'd9, 13'd3,
                  13'd3, 32'd7},
                1'b1, '{32'd0, 17'd0, STAT_SKIP});
        add_row('{3'd7, 16'd5, 17'd9, 13'd3, 13'd3, 13'd0, 16'd20, 17'd9, 13'd3,
                  13'd3, 32'd7},
                1'b1, '{32'd0, 17'd0, STAT_SKIP});
        add_row('{REQ_FILL, 16'd0, 17'd0, 13'd0, 13'd0, 13'd0, 16'd100, 17'd50,
                  13'd0, 13'd5, 32'hAA},
                1'b1, '{32'd0, 17'd0, STAT_SKIP});
        add_row('{REQ_FILL, 16'd0, 17'd0, 13'd0, 13'd0, 13'd0, 16'd100, 17'd0,
                  13'd5, 13'd5, 32'hAA},
                1'b1, '{32'd0, 17'd0, STAT_SKIP});
        add_row('{REQ_FILL, 16'd0, 17'd0, 13'd0, 13'd0, 13'd0, 16'd300, 17'd10,
                  13'd8, 13'd8, 32'hBEEF},
                1'b1, '{32'd0, 17'd10, STAT_BOUND});
        add_row('{REQ_FILL, 16'd0, 17'd0, 13'd0, 13'd0, 13'd0, 16'd65000, 17'd65536,
                  13'h1FFF, 13'd1, 32'hC0DE},
                1'b1, '{32'd0, 17'd4096, STAT_DONE});
        add_row('{REQ_COPY, 16'd10, 17'd0, 13'd4, 13'd4, 13'd0, 16'd900, 17'd64,
                  13'd4, 13'd4, 32'd0},
                1'b1, '{32'd0, 17'd0, STAT_SKIP});
        add_row('{REQ_COPY, 16'd400, 17'd10, 13'd8, 13'd4, 13'd0, 16'd1000, 17'd100,
                  13'd8, 13'd4, 32'd0},
                1'b1, '{32'd0, 17'd8, STAT_BOUND});
        add_row('{REQ_COPY, 16'd65530, 17'd100, 13'd10, 13'd3, 13'd0, 16'd2000,
                  17'd100, 13'd12, 13'd5, 32'd0}, 1'b0, none);
        add_row('{REQ_COPY, 16'd300, 17'd500, 13'd9, 13'd7, 13'd0, 16'd65534,
                  17'd500, 13'd6, 13'd9, 32'd0}, 1'b0, none);
        add_row('{REQ_BUF, 16'd300, 17'd400, 13'd0, 13'd0, 13'd0, 16'd3000,
                  17'd400, 13'd7, 13'd5, 32'd0}, 1'b0, none);
        add_row('{REQ_BUF, 16'd300, 17'd400, 13'd99, 13'd2, 13'd1, 16'd3100,
                  17'd400, 13'd7, 13'd5, 32'd0}, 1'b0, none);
        add_row('{REQ_BUF, 16'd0, 17'd65536, 13'd3, 13'd2, 13'h1FFF, 16'd3200,
                  17'd400, 13'd7, 13'd5, 32'd0}, 1'b0, none);
        add_row('{REQ_SCALE, 16'd700, 17'd500, 13'd5, 13'd5, 13'd0, 16'd700,
                  17'd500, 13'd9, 13'd9, 32'd0},
                1'b1, '{32'd0, 17'd0, STAT_SKIP});
        add_row('{REQ_SCALE, 16'd700, 17'd500, 13'd5, 13'd3, 13'd0, 16'd4000,
                  17'd500, 13'd9, 13'd7, 32'd0}, 1'b0, none);
        add_row('{REQ_SCALE, 16'd700, 17'd500, 13'd9, 13'd8, 13'd0, 16'd4200,
                  17'd500, 13'd4, 13'd3, 32'd0}, 1'b0, none);
        add_row('{REQ_SCALE, 16'd700, 17'd20, 13'd5, 13'd6, 13'd0, 16'd4400,
                  17'd500, 13'd4, 13'd8, 32'd0}, 1'b0, none);
        add_row('{REQ_READ, 16'd0, 17'd0, 13'd0, 13'd0, 13'd0, 16'd4400, 17'd0,
                  13'd0, 13'd0, 32'd0}, 1'b0, none);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (table_req[i])
            offer_request(table_req[i], table_typed[i], table_rsp[i]);
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 150 == 0)
                idle_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
            offer_request(rand_request(), 1'b0, none);
        end
        @(negedge clk);
        req_valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("pixel_blit_engine_unit: match");
        else
            $display("pixel_blit_engine_unit: mismatch");
        $finish;
    end

    initial
    begin
        int       gap;
        pbe_rsp_t want;
        @(posedge rst_n);
        forever
        begin
            gap = $urandom_range(0, idle_max);
            if (rsp_count == 60)
                gap = 400;
            @(negedge clk);
            if (gap > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_valid);
            rsp_count++;
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response %h", rsp);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.read_data !== want.read_data ||
                    rsp.pixels_written !== want.pixels_written ||
                    rsp.status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("response %0d: expected data %h count %0d status %0d, got data %h count %0d status %0d",
                                 rsp_count, want.read_data, want.pixels_written, want.status,
                                 rsp.read_data, rsp.pixels_written, rsp.status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || !rst_n)
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("pixel_blit_engine_unit: mismatch");
                $finish;
            end
        end
    end
endmodule
